// ===== rtl/core/cst_pkg.sv =====
// Shared types, character codes and classification helpers for the C-like tokenizer.
// No dependencies; imported by cst_step, cst_res_fifo and c_like_source_tokenizer.
package cst_pkg;

	localparam int LINE_BITS   = 16;
	localparam int COLUMN_BITS = 16;
	localparam int TAB_BITS    = 5;
	localparam int MAX_RES     = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;
	localparam int RES_NW      = 2;
	localparam int LVL_W       = 3;

	localparam logic [TAB_BITS-1:0]    TAB_RESET = 5'd8;
	localparam logic [LINE_BITS-1:0]   LINE_ONE  = 16'd1;
	localparam logic [LINE_BITS-1:0]   LINE_MAX  = 16'hFFFF;
	localparam logic [COLUMN_BITS-1:0] COL_MAX   = 16'hFFFF;

	// character codes
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_LPAR   = 8'h28;
	localparam logic [7:0] CH_RPAR   = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_0      = 8'h30;
	localparam logic [7:0] CH_9      = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UC_A   = 8'h41;
	localparam logic [7:0] CH_UC_Z   = 8'h5A;
	localparam logic [7:0] CH_LBRK   = 8'h5B;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_RBRK   = 8'h5D;
	localparam logic [7:0] CH_UNDER  = 8'h5F;
	localparam logic [7:0] CH_LC_A   = 8'h61;
	localparam logic [7:0] CH_LC_Z   = 8'h7A;
	localparam logic [7:0] CH_LBRC   = 8'h7B;
	localparam logic [7:0] CH_RBRC   = 8'h7D;

	typedef enum logic [3:0] {
		K_ID         = 4'd0,
		K_INT        = 4'd1,
		K_FLOAT      = 4'd2,
		K_STRING     = 4'd3,
		K_SEMI       = 4'd4,
		K_BRACKET    = 4'd5,
		K_COMMA      = 4'd6,
		K_DOT        = 4'd7,
		K_ASSIGN     = 4'd8,
		K_LOGICAL    = 4'd9,
		K_RELATIONAL = 4'd10,
		K_ARITH      = 4'd11,
		K_ERROR      = 4'd12
	} kind_t;

	typedef enum logic [11:0] {
		M_IDLE       = 12'b0000_0000_0001,
		M_IDENT      = 12'b0000_0000_0010,
		M_NUMBER     = 12'b0000_0000_0100,
		M_STRING     = 12'b0000_0000_1000,
		M_STR_ESC    = 12'b0000_0001_0000,
		M_LOGOP      = 12'b0000_0010_0000,
		M_ARITH      = 12'b0000_0100_0000,
		M_SLASH      = 12'b0000_1000_0000,
		M_LINE_CMT   = 12'b0001_0000_0000,
		M_BLOCK      = 12'b0010_0000_0000,
		M_BLOCK_STAR = 12'b0100_0000_0000,
		M_PEND       = 12'b1000_0000_0000
	} mode_t;

	// lexer state carried between items
	typedef struct packed {
		mode_t                  mode;
		logic [7:0]             held;
		logic                   dp;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
	} lex_state_t;

	// one result record
	typedef struct packed {
		logic                   is_end;
		logic [7:0]             ch;
		kind_t                  kind;
		logic [LINE_BITS-1:0]   line;
		logic [COLUMN_BITS-1:0] col;
		logic                   last;
	} res_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_0) && (c <= CH_9);
	endfunction

	function automatic logic is_letter(input logic [7:0] c);
		return ((c >= CH_LC_A) && (c <= CH_LC_Z)) || ((c >= CH_UC_A) && (c <= CH_UC_Z)) ||
			(c == CH_UNDER);
	endfunction

	function automatic logic is_single(input logic [7:0] c);
		return (c == CH_SEMI) || (c == CH_COMMA) || (c == CH_DOT) || (c == CH_LBRC) ||
			(c == CH_RBRC) || (c == CH_LBRK) || (c == CH_RBRK) || (c == CH_LPAR) ||
			(c == CH_RPAR);
	endfunction

	function automatic kind_t single_kind(input logic [7:0] c);
		kind_t k;
		if (c == CH_SEMI)
			k = K_SEMI;
		else if (c == CH_COMMA)
			k = K_COMMA;
		else if (c == CH_DOT)
			k = K_DOT;
		else
			k = K_BRACKET;
		return k;
	endfunction

	function automatic kind_t lone_op_kind(input logic [7:0] c);
		kind_t k;
		if (c == CH_EQ)
			k = K_ASSIGN;
		else if (c == CH_BANG)
			k = K_LOGICAL;
		else
			k = K_RELATIONAL;
		return k;
	endfunction

	function automatic res_t mk_char(input logic [7:0] c);
		res_t r;
		r        = '0;
		r.ch     = c;
		r.kind   = K_ID;
		return r;
	endfunction

	function automatic res_t mk_close(input kind_t k, input logic [LINE_BITS-1:0] ln,
		input logic [COLUMN_BITS-1:0] cl);
		res_t r;
		r        = '0;
		r.is_end = 1'b1;
		r.kind   = k;
		r.line   = ln;
		r.col    = cl;
		return r;
	endfunction

endpackage

// ===== rtl/core/cst_step.sv =====
// Next-state and result logic of the tokenizer for one source byte or end-of-text mark.
// Purely combinational; depends on cst_pkg.
module cst_step
	import cst_pkg::*;
(
	input  lex_state_t          st,
	input  logic [TAB_BITS-1:0] tab_adv,
	input  logic [7:0]          src,
	input  logic                eot,
	output lex_state_t          st_nx,
	output res_t [MAX_RES-1:0]  res,
	output logic [RES_NW-1:0]   res_n
);

	always_comb begin
		logic [COLUMN_BITS:0]   col_sum;
		logic [COLUMN_BITS-1:0] add;
		logic [LINE_BITS-1:0]   ln_a;
		logic [COLUMN_BITS-1:0] cl_a;
		logic [RES_NW-1:0]      n;
		logic                   feed;

		n     = '0;
		feed  = 1'b0;
		res   = '0;
		st_nx = st;

		// column and line after taking this byte
		add     = (src == CH_TAB) ? {{(COLUMN_BITS-TAB_BITS){1'b0}}, tab_adv}
			: {{(COLUMN_BITS-1){1'b0}}, 1'b1};
		col_sum = {1'b0, st.col} + {1'b0, add};
		if (src == CH_NL) begin
			ln_a = (st.line == LINE_MAX) ? LINE_MAX : st.line + LINE_ONE;
			cl_a = '0;
		end else begin
			ln_a = st.line;
			cl_a = col_sum[COLUMN_BITS] ? COL_MAX : col_sum[COLUMN_BITS-1:0];
		end

		if (eot) begin
			// flush the open token, then restart the text
			case (st.mode)
				M_IDENT: begin
					res[n] = mk_close(K_ID, st.line, st.col); n = n + 1'b1;
				end
				M_NUMBER: begin
					res[n] = mk_close(st.dp ? K_FLOAT : K_INT, st.line, st.col); n = n + 1'b1;
				end
				M_STRING, M_STR_ESC: begin
					res[n] = mk_close(K_ERROR, st.line, st.col); n = n + 1'b1;
				end
				M_LOGOP: begin
					res[n] = mk_close(lone_op_kind(st.held), st.line, st.col); n = n + 1'b1;
				end
				M_ARITH: begin
					res[n] = mk_close(K_ARITH, st.line, st.col); n = n + 1'b1;
				end
				M_SLASH: begin
					res[n] = mk_char(CH_SLASH); n = n + 1'b1;
					res[n] = mk_close(K_ARITH, st.line, st.col); n = n + 1'b1;
				end
				M_PEND: begin
					res[n] = mk_close(single_kind(st.held), st.line, st.col); n = n + 1'b1;
				end
				default: begin
				end
			endcase
			st_nx.mode = M_IDLE;
			st_nx.held = '0;
			st_nx.dp   = 1'b0;
			st_nx.line = LINE_ONE;
			st_nx.col  = '0;
		end else begin
			st_nx.line = ln_a;
			st_nx.col  = cl_a;
			case (st.mode)
				M_IDENT: begin
					if (is_letter(src) || is_digit(src)) begin
						res[n] = mk_char(src); n = n + 1'b1;
					end else begin
						res[n] = mk_close(K_ID, st.line, st.col); n = n + 1'b1;
						feed = 1'b1;
					end
				end
				M_NUMBER: begin
					if (is_digit(src) || (src == CH_DOT)) begin
						res[n] = mk_char(src); n = n + 1'b1;
						if (src == CH_DOT)
							st_nx.dp = 1'b1;
					end else begin
						res[n] = mk_close(st.dp ? K_FLOAT : K_INT, st.line, st.col);
						n = n + 1'b1;
						feed = 1'b1;
					end
				end
				M_STRING: begin
					if (src == CH_NL) begin
						res[n] = mk_close(K_ERROR, st.line, st.col); n = n + 1'b1;
						feed = 1'b1;
					end else if (src == CH_QUOTE) begin
						res[n] = mk_close(K_STRING, ln_a, cl_a); n = n + 1'b1;
						st_nx.mode = M_IDLE;
					end else if (src == CH_BSLASH) begin
						st_nx.mode = M_STR_ESC;
					end else begin
						res[n] = mk_char(src); n = n + 1'b1;
					end
				end
				M_STR_ESC: begin
					if (src == CH_NL) begin
						res[n] = mk_close(K_ERROR, st.line, st.col); n = n + 1'b1;
						feed = 1'b1;
					end else begin
						res[n] = mk_char(src); n = n + 1'b1;
						st_nx.mode = M_STRING;
					end
				end
				M_LOGOP: begin
					if (src == CH_EQ) begin
						res[n] = mk_char(src); n = n + 1'b1;
						res[n] = mk_close(((st.held == CH_EQ) || (st.held == CH_BANG)) ?
							K_LOGICAL : K_RELATIONAL, ln_a, cl_a);
						n = n + 1'b1;
						st_nx.mode = M_IDLE;
					end else begin
						res[n] = mk_close(lone_op_kind(st.held), st.line, st.col);
						n = n + 1'b1;
						feed = 1'b1;
					end
				end
				M_ARITH: begin
					if (src == CH_EQ) begin
						res[n] = mk_char(src); n = n + 1'b1;
						res[n] = mk_close(K_ARITH, ln_a, cl_a); n = n + 1'b1;
						st_nx.mode = M_IDLE;
					end else begin
						res[n] = mk_close(K_ARITH, st.line, st.col); n = n + 1'b1;
						feed = 1'b1;
					end
				end
				M_SLASH: begin
					if (src == CH_SLASH) begin
						st_nx.mode = M_LINE_CMT;
					end else if (src == CH_STAR) begin
						st_nx.mode = M_BLOCK;
					end else if (src == CH_EQ) begin
						res[n] = mk_char(CH_SLASH); n = n + 1'b1;
						res[n] = mk_char(CH_EQ); n = n + 1'b1;
						res[n] = mk_close(K_ARITH, ln_a, cl_a); n = n + 1'b1;
						st_nx.mode = M_IDLE;
					end else begin
						res[n] = mk_char(CH_SLASH); n = n + 1'b1;
						res[n] = mk_close(K_ARITH, st.line, st.col); n = n + 1'b1;
						feed = 1'b1;
					end
				end
				M_LINE_CMT: begin
					if (src == CH_NL)
						feed = 1'b1;
				end
				M_BLOCK: begin
					if (src == CH_STAR)
						st_nx.mode = M_BLOCK_STAR;
				end
				M_BLOCK_STAR: begin
					if (src == CH_SLASH)
						st_nx.mode = M_IDLE;
					else if (src != CH_STAR)
						st_nx.mode = M_BLOCK;
				end
				M_PEND: begin
					res[n] = mk_close(single_kind(st.held), st.line, st.col); n = n + 1'b1;
					feed = 1'b1;
				end
				default: begin
					feed = 1'b1;
				end
			endcase

			// byte taken between tokens
			if (feed) begin
				st_nx.mode = M_IDLE;
				if (is_single(src)) begin
					res[n] = mk_char(src); n = n + 1'b1;
					if (n != 2'd3) begin
						res[n] = mk_close(single_kind(src), ln_a, cl_a); n = n + 1'b1;
					end else begin
						// no room for the close: hold it for the next item
						st_nx.held = src;
						st_nx.mode = M_PEND;
					end
				end else if (src == CH_QUOTE) begin
					st_nx.mode = M_STRING;
				end else if ((src == CH_EQ) || (src == CH_LT) || (src == CH_GT) ||
					(src == CH_BANG)) begin
					res[n] = mk_char(src); n = n + 1'b1;
					st_nx.held = src;
					st_nx.mode = M_LOGOP;
				end else if ((src == CH_PLUS) || (src == CH_MINUS) || (src == CH_STAR)) begin
					res[n] = mk_char(src); n = n + 1'b1;
					st_nx.held = src;
					st_nx.mode = M_ARITH;
				end else if (src == CH_SLASH) begin
					st_nx.mode = M_SLASH;
				end else if (is_digit(src)) begin
					res[n] = mk_char(src); n = n + 1'b1;
					st_nx.dp   = 1'b0;
					st_nx.mode = M_NUMBER;
				end else if (is_letter(src)) begin
					res[n] = mk_char(src); n = n + 1'b1;
					st_nx.mode = M_IDENT;
				end
			end
		end

		// mark the final record of this item
		if (n != '0)
			res[n - 1'b1].last = 1'b1;
		res_n = n;
	end

endmodule

// ===== rtl/core/cst_res_fifo.sv =====
// Result queue: takes up to three records per cycle, hands out one per cycle.
// Depends on cst_pkg.
module cst_res_fifo
	import cst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic [RES_NW-1:0]   push_n,
	input  res_t [MAX_RES-1:0]  push_data,
	input  logic                pop,
	output logic [LVL_W-1:0]    level,
	output res_t                head
);

	res_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  rd_ptr_q;
	logic [FIFO_AW-1:0]  wr_ptr_q;
	logic [LVL_W-1:0]    cnt_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			rd_ptr_q <= rd_ptr_q + {{(FIFO_AW-1){1'b0}}, pop};
			wr_ptr_q <= wr_ptr_q + push_n;
			cnt_q    <= cnt_q + {1'b0, push_n} - {{(LVL_W-1){1'b0}}, pop};
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < MAX_RES; i++) begin
			if (i < int'(push_n))
				mem_q[wr_ptr_q + FIFO_AW'(i)] <= push_data[i];
		end
	end

	assign level = cnt_q;
	assign head  = mem_q[rd_ptr_q];

endmodule

// ===== rtl/core/c_like_source_tokenizer.sv =====
// Streaming tokenizer for a C-like language: one source byte per transfer in, token
// character and token close records out. The first record of an item passes the input
// register and the result queue before it is offered on the output. Throughput: one
// item per cycle while the result queue has room; records leave at one per cycle while
// m_tready is high. Reset (arst_n low): idle mode, line 1, column 0, tab advance 8,
// queue empty. Depends on cst_pkg, cst_step and cst_res_fifo.
module c_like_source_tokenizer
	import cst_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// configuration: tab advance
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [TAB_BITS-1:0] cfg_data,
	// source stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [7:0]          s_tdata,   // [7:0] source_byte
	input  logic                s_tuser,   // [0] end_of_text
	// token stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [47:0]         m_tdata,   // [7:0] token_char, [11:8] token_kind,
	                                       // [27:12] line_number, [43:28] end_column
	output logic                m_tuser,   // [0] is_token_end
	output logic                m_tlast    // last_of_run
);

	logic [TAB_BITS-1:0] tab_q;
	lex_state_t          st_q;
	lex_state_t          st_nx;
	logic                valid_s1;
	logic [7:0]          byte_s1;
	logic                eot_s1;
	res_t [MAX_RES-1:0]  res;
	logic [RES_NW-1:0]   res_n;
	logic [LVL_W-1:0]    level;
	res_t                head;
	logic                pop;
	logic                fits;
	logic                go;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			tab_q <= TAB_RESET;
		else if (cfg_valid)
			tab_q <= cfg_data;
	end

	// input register
	assign s_tready = !valid_s1 || go;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (s_tready)
			valid_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			eot_s1  <= s_tuser;
		end
	end

	cst_step u_step (
		.st      (st_q),
		.tab_adv (tab_q),
		.src     (byte_s1),
		.eot     (eot_s1),
		.st_nx   (st_nx),
		.res     (res),
		.res_n   (res_n)
	);

	// item goes ahead when its records fit after this cycle's pop
	assign pop  = m_tvalid && m_tready;
	assign fits = ({1'b0, level} + {2'b00, res_n}) <=
		((LVL_W+1)'(FIFO_DEPTH) + {{LVL_W{1'b0}}, pop});
	assign go   = valid_s1 && fits;

	// lexer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q.mode <= M_IDLE;
			st_q.held <= '0;
			st_q.dp   <= 1'b0;
			st_q.line <= LINE_ONE;
			st_q.col  <= '0;
		end else if (go) begin
			st_q <= st_nx;
		end
	end

	cst_res_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (go ? res_n : '0),
		.push_data (res),
		.pop       (pop),
		.level     (level),
		.head      (head)
	);

	// output packing
	assign m_tvalid = (level != '0);
	assign m_tdata  = {4'b0000, head.col, head.line, head.kind, head.ch};
	assign m_tuser  = head.is_end;
	assign m_tlast  = head.last;

endmodule

// ===== rtl/core/cst_checker.sv =====
// Port-level checks on the tokenizer's output stream, bound to the top level.
// Depends on c_like_source_tokenizer.
module cst_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled output transfer holds its record
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("output record changed while stalled");

	// close records carry a defined token kind
	a_kind_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[11:8] <= 4'd12)
		else $error("close record with undefined kind");

	// character records carry no kind, line or column
	a_char_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[47:8] == 40'd0)
		else $error("character record with non-zero close fields");

	// line numbers count from one
	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[27:12] != 16'd0)
		else $error("close record with line zero");

endmodule

bind c_like_source_tokenizer cst_checker u_cst_checker (.*);
